// File: rtl/core/cte_pkg.sv
package cte_pkg;

  localparam int CTE_QUEUE_DEPTH = 4;

  typedef enum logic [5:0] {
    CMD_BCC = 6'd0,
    CMD_BCS = 6'd1,
    CMD_BEQ = 6'd2,
    CMD_BMI = 6'd3,
    CMD_BNE = 6'd4,
    CMD_BPL = 6'd5,
    CMD_BRK = 6'd6,
    CMD_BVC = 6'd7,
    CMD_BVS = 6'd8,
    CMD_CLC = 6'd9,
    CMD_CLD = 6'd10,
    CMD_CLI = 6'd11,
    CMD_CLV = 6'd12,
    CMD_DEX = 6'd13,
    CMD_DEY = 6'd14,
    CMD_INX = 6'd15,
    CMD_INY = 6'd16,
    CMD_JMPI = 6'd17,
    CMD_JMPA = 6'd18,
    CMD_JSR = 6'd19,
    CMD_NOP = 6'd20,
    CMD_PHA = 6'd21,
    CMD_PHP = 6'd22,
    CMD_PLA = 6'd23,
    CMD_PLP = 6'd24,
    CMD_RTI = 6'd25,
    CMD_RTS = 6'd26,
    CMD_SEC = 6'd27,
    CMD_SED = 6'd28,
    CMD_SEI = 6'd29,
    CMD_TAX = 6'd30,
    CMD_TAY = 6'd31,
    CMD_TSX = 6'd32,
    CMD_TXA = 6'd33,
    CMD_TXS = 6'd34,
    CMD_TYA = 6'd35
  } cmd_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_BRANCH,
    OP_BRK,
    OP_FLAG,
    OP_INX,
    OP_INY,
    OP_DEX,
    OP_DEY,
    OP_JMP,
    OP_JSR,
    OP_PHA,
    OP_PHP,
    OP_PLA,
    OP_PLP,
    OP_RTI,
    OP_RTS,
    OP_TAX,
    OP_TAY,
    OP_TSX,
    OP_TXA,
    OP_TXS,
    OP_TYA
  } op_t;

  localparam logic [2:0] BIT_C = 3'd0;
  localparam logic [2:0] BIT_Z = 3'd1;
  localparam logic [2:0] BIT_V = 3'd6;
  localparam logic [2:0] BIT_N = 3'd7;

  localparam logic [7:0] MASK_C = 8'h01;
  localparam logic [7:0] MASK_I = 8'h04;
  localparam logic [7:0] MASK_D = 8'h08;
  localparam logic [7:0] MASK_B = 8'h10;
  localparam logic [7:0] MASK_V = 8'h40;

  localparam logic [15:0] BRK_VEC_HI_ADDR = 16'hFFFF;
  localparam logic [7:0]  SP_RESET        = 8'hFF;

  typedef struct packed {
    op_t         op;
    logic [2:0]  br_idx;
    logic        br_set;
    logic [7:0]  flag_mask;
    logic        flag_set;
    logic [1:0]  last_step;
    logic [7:0]  offset;
    logic [15:0] target;
    logic [15:0] faddr;
  } dec_t;

endpackage

// File: rtl/core/cpu_control_transfer_executor_top.sv
// Channel  | Direction | Handshake          | Ports
// input    | in        | push / full        | in_cmd, in_operand_lo/hi, in_fetched_lo/hi
// result   | out       | empty / pop        | out_pc_out .. out_fetch_address
//
// Front stage takes and decodes an item per cycle unless a full queue stalls it;
// a short queue feeds the executor. The executor steps stack items through the
// single-port stack RAM one byte at a time; pulls end with a step that takes the registered read data.
// Reset is synchronous; stack valid bits clear at once.
// A full result register stalls the executor; a full queue stalls the front.
module cpu_control_transfer_executor_top #(
  parameter int QUEUE_DEPTH = cte_pkg::CTE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [5:0]  in_cmd,
  input  logic [7:0]  in_operand_lo,
  input  logic [7:0]  in_operand_hi,
  input  logic [7:0]  in_fetched_lo,
  input  logic [7:0]  in_fetched_hi,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_pc_out,
  output logic [7:0]  out_acc_out,
  output logic [7:0]  out_x_out,
  output logic [7:0]  out_y_out,
  output logic [7:0]  out_sp_out,
  output logic [7:0]  out_status_out,
  output logic [15:0] out_fetch_address
);
  import cte_pkg::*;

  logic fq_push;
  dec_t fq_item;
  logic fq_full;
  logic bq_vld;
  dec_t bq_item;
  logic bq_pop;

  cte_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_cmd        (in_cmd),
    .in_operand_lo (in_operand_lo),
    .in_operand_hi (in_operand_hi),
    .in_fetched_lo (in_fetched_lo),
    .in_fetched_hi (in_fetched_hi),
    .q_push        (fq_push),
    .q_item        (fq_item),
    .q_full        (fq_full)
  );

  cte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_item (fq_item),
    .full      (fq_full),
    .vld       (bq_vld),
    .head_item (bq_item),
    .pop       (bq_pop)
  );

  cte_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_vld             (bq_vld),
    .q_item            (bq_item),
    .q_pop             (bq_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_pc_out        (out_pc_out),
    .out_acc_out       (out_acc_out),
    .out_x_out         (out_x_out),
    .out_y_out         (out_y_out),
    .out_sp_out        (out_sp_out),
    .out_status_out    (out_status_out),
    .out_fetch_address (out_fetch_address)
  );

endmodule

// File: rtl/core/cte_front.sv
module cte_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [5:0]    in_cmd,
  input  logic [7:0]    in_operand_lo,
  input  logic [7:0]    in_operand_hi,
  input  logic [7:0]    in_fetched_lo,
  input  logic [7:0]    in_fetched_hi,
  output logic          q_push,
  output cte_pkg::dec_t q_item,
  input  logic          q_full
);
  import cte_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  dec_t  item_r;
  dec_t  dec;
  logic  accept;

  assign in_full = vld_r && q_full;
  assign accept  = in_push && !in_full;
  assign vld_nxt = accept || (vld_r && q_full);
  assign q_push  = vld_r;
  assign q_item  = item_r;

  always_comb begin
    dec           = '0;
    dec.op        = OP_NOP;
    dec.offset    = in_operand_lo;
    dec.target    = {in_operand_hi, in_operand_lo};
    case (cmd_t'(in_cmd))
      CMD_BCC: begin dec.op = OP_BRANCH; dec.br_idx = BIT_C; dec.br_set = 1'b0; end
      CMD_BCS: begin dec.op = OP_BRANCH; dec.br_idx = BIT_C; dec.br_set = 1'b1; end
      CMD_BEQ: begin dec.op = OP_BRANCH; dec.br_idx = BIT_Z; dec.br_set = 1'b1; end
      CMD_BMI: begin dec.op = OP_BRANCH; dec.br_idx = BIT_N; dec.br_set = 1'b1; end
      CMD_BNE: begin dec.op = OP_BRANCH; dec.br_idx = BIT_Z; dec.br_set = 1'b0; end
      CMD_BPL: begin dec.op = OP_BRANCH; dec.br_idx = BIT_N; dec.br_set = 1'b0; end
      CMD_BVC: begin dec.op = OP_BRANCH; dec.br_idx = BIT_V; dec.br_set = 1'b0; end
      CMD_BVS: begin dec.op = OP_BRANCH; dec.br_idx = BIT_V; dec.br_set = 1'b1; end
      CMD_BRK: begin
        dec.op        = OP_BRK;
        dec.last_step = 2'd2;
        dec.target    = {in_fetched_hi, in_fetched_lo};
        dec.faddr     = BRK_VEC_HI_ADDR;
      end
      CMD_CLC: begin dec.op = OP_FLAG; dec.flag_mask = MASK_C; dec.flag_set = 1'b0; end
      CMD_CLD: begin dec.op = OP_FLAG; dec.flag_mask = MASK_D; dec.flag_set = 1'b0; end
      CMD_CLI: begin dec.op = OP_FLAG; dec.flag_mask = MASK_I; dec.flag_set = 1'b0; end
      CMD_CLV: begin dec.op = OP_FLAG; dec.flag_mask = MASK_V; dec.flag_set = 1'b0; end
      CMD_SEC: begin dec.op = OP_FLAG; dec.flag_mask = MASK_C; dec.flag_set = 1'b1; end
      CMD_SED: begin dec.op = OP_FLAG; dec.flag_mask = MASK_D; dec.flag_set = 1'b1; end
      CMD_SEI: begin dec.op = OP_FLAG; dec.flag_mask = MASK_I; dec.flag_set = 1'b1; end
      CMD_DEX: dec.op = OP_DEX;
      CMD_DEY: dec.op = OP_DEY;
      CMD_INX: dec.op = OP_INX;
      CMD_INY: dec.op = OP_INY;
      CMD_JMPI: begin
        dec.op     = OP_JMP;
        dec.target = {in_fetched_hi, in_fetched_lo};
        dec.faddr  = (in_operand_lo == 8'hFF) ? {in_operand_hi, 8'h00}
                                              : {in_operand_hi, in_operand_lo} + 16'd1;
      end
      CMD_JMPA: dec.op = OP_JMP;
      CMD_JSR: begin dec.op = OP_JSR; dec.last_step = 2'd1; end
      CMD_PHA: dec.op = OP_PHA;
      CMD_PHP: dec.op = OP_PHP;
      CMD_PLA: begin dec.op = OP_PLA; dec.last_step = 2'd1; end
      CMD_PLP: begin dec.op = OP_PLP; dec.last_step = 2'd1; end
      CMD_RTI: begin dec.op = OP_RTI; dec.last_step = 2'd3; end
      CMD_RTS: begin dec.op = OP_RTS; dec.last_step = 2'd2; end
      CMD_TAX: dec.op = OP_TAX;
      CMD_TAY: dec.op = OP_TAY;
      CMD_TSX: dec.op = OP_TSX;
      CMD_TXA: dec.op = OP_TXA;
      CMD_TXS: dec.op = OP_TXS;
      CMD_TYA: dec.op = OP_TYA;
      default: dec.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= dec;
    end
  end

endmodule

// File: rtl/core/cte_queue.sv
module cte_queue #(
  parameter int DEPTH = cte_pkg::CTE_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cte_pkg::dec_t push_item,
  output logic          full,
  output logic          vld,
  output cte_pkg::dec_t head_item,
  input  logic          pop
);
  import cte_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  dec_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign vld       = (cnt_r != '0);
  assign head_item = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/core/cte_back.sv
module cte_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_vld,
  input  cte_pkg::dec_t q_item,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [15:0]   out_pc_out,
  output logic [7:0]    out_acc_out,
  output logic [7:0]    out_x_out,
  output logic [7:0]    out_y_out,
  output logic [7:0]    out_sp_out,
  output logic [7:0]    out_status_out,
  output logic [15:0]   out_fetch_address
);
  import cte_pkg::*;

  function automatic logic [7:0] zn_upd(input logic [7:0] p, input logic [7:0] v);
    zn_upd = {v[7], p[6:2], (v == 8'd0), p[0]};
  endfunction

  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  a_r, a_nxt;
  logic [7:0]  x_r, x_nxt;
  logic [7:0]  y_r, y_nxt;
  logic [7:0]  sp_r, sp_nxt;
  logic [7:0]  p_r, p_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [1:0]  step_r;

  logic [7:0]  stk_mem [256];
  logic [255:0] stk_vld_r;
  logic [7:0]  rd_q_r;
  logic        rd_vld_r;

  logic        out_vld_r;
  logic [15:0] res_pc_r;
  logic [7:0]  res_a_r, res_x_r, res_y_r, res_sp_r, res_p_r;
  logic [15:0] res_faddr_r;

  logic        fire;
  logic        last;
  logic        done;
  logic        mem_we;
  logic        mem_re;
  logic [7:0]  mem_addr;
  logic [7:0]  wdata;
  logic [7:0]  rdata;
  logic [15:0] pc1;
  logic        br_take;
  logic [7:0]  x_inc, x_dec, y_inc, y_dec;

  assign fire     = q_vld && (!out_vld_r || out_pop);
  assign last     = (step_r == q_item.last_step);
  assign done     = fire && last;
  assign q_pop    = done;
  assign pc1      = pc_r + 16'd1;
  assign br_take  = (p_r[q_item.br_idx] == q_item.br_set);
  assign rdata    = rd_vld_r ? rd_q_r : 8'h00;
  assign mem_addr = mem_we ? sp_r : sp_r + 8'd1;
  assign x_inc    = x_r + 8'd1;
  assign x_dec    = x_r - 8'd1;
  assign y_inc    = y_r + 8'd1;
  assign y_dec    = y_r - 8'd1;

  always_comb begin
    pc_nxt = pc_r;
    a_nxt  = a_r;
    x_nxt  = x_r;
    y_nxt  = y_r;
    sp_nxt = sp_r;
    p_nxt  = p_r;
    lo_nxt = lo_r;
    mem_we = 1'b0;
    mem_re = 1'b0;
    wdata  = 8'h00;
    case (q_item.op)
      OP_BRANCH: begin
        pc_nxt = br_take ? pc1 + {{8{q_item.offset[7]}}, q_item.offset} : pc1;
      end
      OP_BRK: begin
        mem_we = 1'b1;
        sp_nxt = sp_r - 8'd1;
        case (step_r)
          2'd0:    wdata = pc1[15:8];
          2'd1:    wdata = pc1[7:0];
          default: wdata = p_r | MASK_B;
        endcase
        if (last) begin
          p_nxt  = p_r | MASK_B | MASK_I;
          pc_nxt = q_item.target;
        end
      end
      OP_FLAG: begin
        p_nxt = q_item.flag_set ? (p_r | q_item.flag_mask) : (p_r & ~q_item.flag_mask);
      end
      OP_INX: begin x_nxt = x_inc; p_nxt = zn_upd(p_r, x_inc); end
      OP_INY: begin y_nxt = y_inc; p_nxt = zn_upd(p_r, y_inc); end
      OP_DEX: begin x_nxt = x_dec; p_nxt = zn_upd(p_r, x_dec); end
      OP_DEY: begin y_nxt = y_dec; p_nxt = zn_upd(p_r, y_dec); end
      OP_JMP: pc_nxt = q_item.target;
      OP_JSR: begin
        mem_we = 1'b1;
        sp_nxt = sp_r - 8'd1;
        wdata  = (step_r == 2'd0) ? pc1[15:8] : pc1[7:0];
        if (last) begin
          pc_nxt = q_item.target;
        end
      end
      OP_PHA: begin mem_we = 1'b1; sp_nxt = sp_r - 8'd1; wdata = a_r; end
      OP_PHP: begin mem_we = 1'b1; sp_nxt = sp_r - 8'd1; wdata = p_r; end
      OP_PLA, OP_PLP, OP_RTI, OP_RTS: begin
        if (!last) begin
          mem_re = 1'b1;
          sp_nxt = sp_r + 8'd1;
        end
        case (q_item.op)
          OP_PLA: begin
            if (last) begin
              a_nxt = rdata;
              p_nxt = zn_upd(p_r, rdata);
            end
          end
          OP_PLP: begin
            if (last) begin
              p_nxt = rdata;
            end
          end
          OP_RTS: begin
            if (step_r == 2'd1) begin
              lo_nxt = rdata;
            end
            if (last) begin
              pc_nxt = {rdata, lo_r} + 16'd1;
            end
          end
          default: begin
            if (step_r == 2'd1) begin
              p_nxt = rdata;
            end
            if (step_r == 2'd2) begin
              lo_nxt = rdata;
            end
            if (last) begin
              pc_nxt = {rdata, lo_r};
            end
          end
        endcase
      end
      OP_TAX: begin x_nxt = a_r;  p_nxt = zn_upd(p_r, a_r); end
      OP_TAY: begin y_nxt = a_r;  p_nxt = zn_upd(p_r, a_r); end
      OP_TSX: begin x_nxt = sp_r; p_nxt = zn_upd(p_r, sp_r); end
      OP_TXA: begin a_nxt = x_r;  p_nxt = zn_upd(p_r, x_r); end
      OP_TXS: sp_nxt = x_r;
      OP_TYA: begin a_nxt = y_r;  p_nxt = zn_upd(p_r, y_r); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      a_r       <= '0;
      x_r       <= '0;
      y_r       <= '0;
      sp_r      <= SP_RESET;
      p_r       <= '0;
      step_r    <= '0;
      stk_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (fire) begin
        pc_r   <= pc_nxt;
        a_r    <= a_nxt;
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        sp_r   <= sp_nxt;
        p_r    <= p_nxt;
        step_r <= last ? 2'd0 : step_r + 2'd1;
        if (mem_we) begin
          stk_vld_r[mem_addr] <= 1'b1;
        end
      end
      if (done) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      lo_r <= lo_nxt;
    end
    if (fire && mem_we) begin
      stk_mem[mem_addr] <= wdata;
    end
    if (fire && mem_re) begin
      rd_q_r   <= stk_mem[mem_addr];
      rd_vld_r <= stk_vld_r[mem_addr];
    end
    if (done) begin
      res_pc_r    <= pc_nxt;
      res_a_r     <= a_nxt;
      res_x_r     <= x_nxt;
      res_y_r     <= y_nxt;
      res_sp_r    <= sp_nxt;
      res_p_r     <= p_nxt;
      res_faddr_r <= q_item.faddr;
    end
  end

  assign out_empty         = !out_vld_r;
  assign out_pc_out        = res_pc_r;
  assign out_acc_out       = res_a_r;
  assign out_x_out         = res_x_r;
  assign out_y_out         = res_y_r;
  assign out_sp_out        = res_sp_r;
  assign out_status_out    = res_p_r;
  assign out_fetch_address = res_faddr_r;

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_vld |-> (step_r <= q_item.last_step))
    else $error("step beyond last step of item");

  a_step_held: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != 2'd0) |-> q_vld)
    else $error("item left queue mid-sequence");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("stack read and write in one cycle");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_vld_r)
    else $error("finished item not shown on output");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(sp_r) && $stable(pc_r) && $stable(step_r)))
    else $error("state moved while stalled");
`endif

endmodule

// File: bench/cpu_control_transfer_executor_top_test.sv
`timescale 1ns / 100ps

module cpu_control_transfer_executor_top_test;
  import cte_pkg::*;

  localparam logic [5:0] CMD_UNKNOWN_LO = 6'd36;
  localparam logic [5:0] CMD_UNKNOWN_HI = 6'd63;
  localparam int RANDOM_ITEMS = 1200;
  localparam int MAX_GAP = 18;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [5:0] cmd;
    logic [7:0] op_lo;
    logic [7:0] op_hi;
    logic [7:0] fe_lo;
    logic [7:0] fe_hi;
    logic       wait_drain;
  } instr_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  st;
    logic [15:0] faddr;
  } regfile_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [5:0]  in_cmd = '0;
  logic [7:0]  in_operand_lo = '0;
  logic [7:0]  in_operand_hi = '0;
  logic [7:0]  in_fetched_lo = '0;
  logic [7:0]  in_fetched_hi = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_pc_out;
  logic [7:0]  out_acc_out;
  logic [7:0]  out_x_out;
  logic [7:0]  out_y_out;
  logic [7:0]  out_sp_out;
  logic [7:0]  out_status_out;
  logic [15:0] out_fetch_address;

  cpu_control_transfer_executor_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_cmd            (in_cmd),
    .in_operand_lo     (in_operand_lo),
    .in_operand_hi     (in_operand_hi),
    .in_fetched_lo     (in_fetched_lo),
    .in_fetched_hi     (in_fetched_hi),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_pc_out        (out_pc_out),
    .out_acc_out       (out_acc_out),
    .out_x_out         (out_x_out),
    .out_y_out         (out_y_out),
    .out_sp_out        (out_sp_out),
    .out_status_out    (out_status_out),
    .out_fetch_address (out_fetch_address)
  );

  instr_t   instr_queue[$];
  regfile_t expected_regs[$];
  instr_t   cur_instr;

  logic [15:0] cpu_pc = '0;
  logic [7:0]  cpu_a = '0;
  logic [7:0]  cpu_x = '0;
  logic [7:0]  cpu_y = '0;
  logic [7:0]  cpu_sp = SP_RESET;
  logic [7:0]  cpu_p = '0;
  logic [7:0]  stack_mem [256];

  int items_sent = 0;
  int results_checked = 0;
  int error_count = 0;
  int branches_taken = 0;
  int stack_accesses = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_gap = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 256; i++) stack_mem[i] = '0;
  end

  function automatic void stk_push(logic [7:0] value);
    stack_mem[cpu_sp] = value;
    cpu_sp = cpu_sp - 8'd1;
    stack_accesses++;
  endfunction

  function automatic logic [7:0] stk_pop();
    cpu_sp = cpu_sp + 8'd1;
    stack_accesses++;
    return stack_mem[cpu_sp];
  endfunction

  function automatic void set_zn(logic [7:0] value);
    cpu_p[BIT_Z] = (value == 8'h00);
    cpu_p[BIT_N] = value[7];
  endfunction

  function automatic void take_branch(logic cond, logic [7:0] offset);
    cpu_pc = cpu_pc + 16'd1;
    if (cond) begin
      cpu_pc = cpu_pc + {{8{offset[7]}}, offset};
      branches_taken++;
    end
  endfunction

  function automatic regfile_t execute_instr(instr_t it);
    logic [15:0] ret_addr;
    logic [15:0] fetch_addr;
    logic [7:0]  lo;
    logic [7:0]  hi;
    regfile_t    r;
    fetch_addr = '0;
    case (it.cmd)
      CMD_BCC: take_branch(!cpu_p[BIT_C], it.op_lo);
      CMD_BCS: take_branch(cpu_p[BIT_C], it.op_lo);
      CMD_BEQ: take_branch(cpu_p[BIT_Z], it.op_lo);
      CMD_BMI: take_branch(cpu_p[BIT_N], it.op_lo);
      CMD_BNE: take_branch(!cpu_p[BIT_Z], it.op_lo);
      CMD_BPL: take_branch(!cpu_p[BIT_N], it.op_lo);
      CMD_BVC: take_branch(!cpu_p[BIT_V], it.op_lo);
      CMD_BVS: take_branch(cpu_p[BIT_V], it.op_lo);
      CMD_BRK: begin
        cpu_p = cpu_p | MASK_B;
        ret_addr = cpu_pc + 16'd1;
        stk_push(ret_addr[15:8]);
        stk_push(ret_addr[7:0]);
        stk_push(cpu_p);
        cpu_p = cpu_p | MASK_I;
        cpu_pc = {it.fe_hi, it.fe_lo};
        fetch_addr = BRK_VEC_HI_ADDR;
      end
      CMD_CLC: cpu_p = cpu_p & ~MASK_C;
      CMD_CLD: cpu_p = cpu_p & ~MASK_D;
      CMD_CLI: cpu_p = cpu_p & ~MASK_I;
      CMD_CLV: cpu_p = cpu_p & ~MASK_V;
      CMD_SEC: cpu_p = cpu_p | MASK_C;
      CMD_SED: cpu_p = cpu_p | MASK_D;
      CMD_SEI: cpu_p = cpu_p | MASK_I;
      CMD_DEX: begin
        cpu_x = cpu_x - 8'd1;
        set_zn(cpu_x);
      end
      CMD_DEY: begin
        cpu_y = cpu_y - 8'd1;
        set_zn(cpu_y);
      end
      CMD_INX: begin
        cpu_x = cpu_x + 8'd1;
        set_zn(cpu_x);
      end
      CMD_INY: begin
        cpu_y = cpu_y + 8'd1;
        set_zn(cpu_y);
      end
      CMD_JMPI: begin
        fetch_addr = (it.op_lo == 8'hFF) ? {it.op_hi, 8'h00}
                                         : {it.op_hi, it.op_lo} + 16'd1;
        cpu_pc = {it.fe_hi, it.fe_lo};
      end
      CMD_JMPA: cpu_pc = {it.op_hi, it.op_lo};
      CMD_JSR: begin
        ret_addr = cpu_pc + 16'd1;
        stk_push(ret_addr[15:8]);
        stk_push(ret_addr[7:0]);
        cpu_pc = {it.op_hi, it.op_lo};
      end
      CMD_PHA: stk_push(cpu_a);
      CMD_PHP: stk_push(cpu_p);
      CMD_PLA: begin
        cpu_a = stk_pop();
        set_zn(cpu_a);
      end
      CMD_PLP: cpu_p = stk_pop();
      CMD_RTI: begin
        cpu_p = stk_pop();
        lo = stk_pop();
        hi = stk_pop();
        cpu_pc = {hi, lo};
      end
      CMD_RTS: begin
        lo = stk_pop();
        hi = stk_pop();
        cpu_pc = {hi, lo} + 16'd1;
      end
      CMD_TAX: begin
        cpu_x = cpu_a;
        set_zn(cpu_x);
      end
      CMD_TAY: begin
        cpu_y = cpu_a;
        set_zn(cpu_y);
      end
      CMD_TSX: begin
        cpu_x = cpu_sp;
        set_zn(cpu_x);
      end
      CMD_TXA: begin
        cpu_a = cpu_x;
        set_zn(cpu_a);
      end
      CMD_TXS: cpu_sp = cpu_x;
      CMD_TYA: begin
        cpu_a = cpu_y;
        set_zn(cpu_a);
      end
      default: ;
    endcase
    r.pc = cpu_pc;
    r.acc = cpu_a;
    r.x = cpu_x;
    r.y = cpu_y;
    r.sp = cpu_sp;
    r.st = cpu_p;
    r.faddr = fetch_addr;
    return r;
  endfunction

  function automatic void add_instr(logic [5:0] cmd, logic [7:0] op_lo, logic [7:0] op_hi,
                                    logic [7:0] fe_lo, logic [7:0] fe_hi);
    instr_t it;
    it.cmd = cmd;
    it.op_lo = op_lo;
    it.op_hi = op_hi;
    it.fe_lo = fe_lo;
    it.fe_hi = fe_hi;
    it.wait_drain = (instr_queue.size() % 500 == 450);
    instr_queue.push_back(it);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_random(logic [5:0] cmd);
    add_instr(cmd, pick_byte(), pick_byte(), pick_byte(), pick_byte());
  endfunction

  // keep the stack untouched between a call, break or push and its return or pull
  function automatic logic [5:0] filler_cmd();
    logic [5:0] cmd;
    cmd = 6'($urandom_range(CMD_BCC, CMD_TYA));
    case (cmd)
      CMD_BRK, CMD_JSR, CMD_PHA, CMD_PHP, CMD_PLA, CMD_PLP,
      CMD_RTI, CMD_RTS, CMD_TXS: cmd = CMD_NOP;
      default: ;
    endcase
    return cmd;
  endfunction

  function automatic int draw_gap(logic burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : driver
    logic offer;
    if (!rst_n) begin
      in_push <= 1'b0;
      send_gap = 0;
    end else begin
      offer = in_push;
      if (in_push && !in_full) begin
        expected_regs.push_back(execute_instr(cur_instr));
        items_sent++;
        offer = 1'b0;
        send_gap = draw_gap((items_sent / 97) % 3 == 0);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (instr_queue.size() > 0 &&
                     !(instr_queue[0].wait_drain && expected_regs.size() != 0)) begin
          cur_instr = instr_queue.pop_front();
          in_cmd <= cur_instr.cmd;
          in_operand_lo <= cur_instr.op_lo;
          in_operand_hi <= cur_instr.op_hi;
          in_fetched_lo <= cur_instr.fe_lo;
          in_fetched_hi <= cur_instr.fe_hi;
          offer = 1'b1;
        end
      end
      in_push <= offer;
    end
  end

  always @(posedge clk) begin : monitor
    regfile_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_regs.size() == 0) begin
          $error("unexpected item: pc_out %h", out_pc_out);
          error_count++;
        end else begin
          want = expected_regs.pop_front();
          check_field("pc_out", want.pc, out_pc_out);
          check_field("acc_out", 16'(want.acc), 16'(out_acc_out));
          check_field("x_out", 16'(want.x), 16'(out_x_out));
          check_field("y_out", 16'(want.y), 16'(out_y_out));
          check_field("sp_out", 16'(want.sp), 16'(out_sp_out));
          check_field("status_out", 16'(want.st), 16'(out_status_out));
          check_field("fetch_address", want.faddr, out_fetch_address);
        end
        results_checked++;
        if (results_checked % 500 == 200) recv_gap = LONG_HOLD;
        else recv_gap = draw_gap((results_checked / 89) % 3 == 1);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int k;
    int depth;
    add_instr(CMD_NOP, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_BCC, 8'h7F, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_SEC, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_BCS, 8'h80, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_BEQ, 8'hFF, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_INX, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_DEX, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_BNE, 8'h10, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_BEQ, 8'h01, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_DEY, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_BPL, 8'h20, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_BMI, 8'hFE, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_BVC, 8'h05, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_BVS, 8'h05, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_JMPA, 8'hFF, 8'hFF, 8'h00, 8'h00);
    add_instr(CMD_CLC, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_BCC, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_JSR, 8'h34, 8'h12, 8'h00, 8'h00);
    add_instr(CMD_PHA, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_PHP, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_PLA, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_PLP, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_RTS, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_JMPI, 8'hFF, 8'h12, 8'hCD, 8'hAB);
    add_instr(CMD_JMPI, 8'hFE, 8'hFF, 8'h00, 8'h80);
    add_instr(CMD_BRK, 8'h00, 8'h00, 8'hFF, 8'hFF);
    add_instr(CMD_RTI, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_TSX, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_TXA, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_TAY, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_INY, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_TYA, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_TAX, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_TXS, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_SED, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_SEI, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_CLD, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_CLI, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_CLV, 8'h00, 8'h00, 8'h00, 8'h00);
    add_instr(CMD_UNKNOWN_LO, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_instr(CMD_UNKNOWN_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    k = instr_queue.size() + RANDOM_ITEMS;
    while (instr_queue.size() < k) begin
      case ($urandom_range(0, 9))
        6: begin
          add_random(CMD_JSR);
          repeat ($urandom_range(0, 3)) add_random(filler_cmd());
          add_random(CMD_RTS);
        end
        7: begin
          add_random(CMD_BRK);
          repeat ($urandom_range(0, 3)) add_random(filler_cmd());
          add_random(CMD_RTI);
        end
        8: begin
          depth = $urandom_range(1, 4);
          repeat (depth) add_random($urandom_range(0, 1) ? CMD_PHA : CMD_PHP);
          repeat ($urandom_range(0, 2)) add_random(filler_cmd());
          repeat (depth) add_random($urandom_range(0, 1) ? CMD_PLA : CMD_PLP);
        end
        default: begin
          if ($urandom_range(0, 15) == 0)
            add_random(6'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)));
          else
            add_random(6'($urandom_range(CMD_BCC, CMD_TYA)));
        end
      endcase
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (instr_queue.size() != 0 || in_push) @(posedge clk);
    while (expected_regs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d instructions through the executor, %0d register sets compared",
             items_sent, results_checked);
    $display("Covered %0d taken branches and %0d stack page accesses, incl. long back-pressure",
             branches_taken, stack_accesses);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cte_pkg.sv
rtl/core/cte_front.sv
rtl/core/cte_queue.sv
rtl/core/cte_back.sv
rtl/core/cpu_control_transfer_executor_top.sv
bench/cpu_control_transfer_executor_top_test.sv
